### rtl/lr_pkg.sv
`timescale 1ns / 1ps

package lr_pkg;

  // Coordinate width of endpoints and emitted pixels (signed).
  localparam int COORD_BITS = 16;
  // Absolute span of one axis: one bit more than a coordinate.
  localparam int SPAN_W     = COORD_BITS + 1;
  // Error term, signed; wide enough that it never overflows.
  localparam int ERR_W      = COORD_BITS + 3;
  // Screen size registers.
  localparam int SCREEN_W   = 11;
  // Clip compare width: covers a sign-extended coordinate and a screen size.
  localparam int CMP_W      = ((COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W) + 1;
  localparam int COLOR_W    = 16;

  // Configuration register map.
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RST  = 11'd240;
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RST = 11'd320;

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } lr_mode_e;

  typedef struct packed {
    lr_mode_e                       mode;
    logic signed [COORD_BITS-1:0]   x_start;
    logic signed [COORD_BITS-1:0]   y_start;
    logic signed [COORD_BITS-1:0]   x_end;
    logic signed [COORD_BITS-1:0]   y_end;
    logic        [COLOR_W-1:0]      color;
  } lr_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0]   pixel_x;
    logic signed [COORD_BITS-1:0]   pixel_y;
    logic        [COLOR_W-1:0]      pixel_color;
    logic                           on_screen;
    logic                           last_pixel;
  } lr_pix_t;

  // Result of one accepted beat from the core to the output buffer.
  typedef struct packed {
    logic    valid;
    lr_pix_t pix;
  } lr_res_t;

endpackage

### rtl/line_rasterizer.sv
`timescale 1ns / 1ps

// Bresenham line rasterizer. A start beat (mode 0) latches both endpoints and
// the colour and produces no pixel; each advance beat (mode 1) produces the
// next pixel of the line, first endpoint to second inclusive, with
// last_pixel set on the second endpoint, after which the line is idle and
// further advances produce nothing. A start beat at any time restarts.
// on_screen is clear for pixels with a negative coordinate or one at or
// beyond the screen_width / screen_height registers; such pixels are still
// delivered and are for the consumer to drop. Throughput is one input beat
// per clock while in_stall_o is low: one error-term step (compare and add)
// runs between the line state registers and a two-deep output buffer, and
// the pixel of an accepted advance beat is registered into that buffer.
// in_stall_o rises only once both output slots hold pixels, i.e. the
// consumer has stalled a pixel at the same edge as the next one arrived.
// Configuration writes take effect on the next clock and are meant to be
// made while no line pixels are outstanding.
module line_rasterizer import lr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCREEN_W-1:0]  cfg_data_i,
  // input beats
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  lr_in_t               in_data_i,
  // pixel beats
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lr_pix_t              out_data_o
);

  logic [SCREEN_W-1:0] screen_width_q;
  logic [SCREEN_W-1:0] screen_height_q;
  logic                in_fire;
  lr_res_t             res;
  logic                buf_full;
  logic                busy;

  // screen size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= SCREEN_WIDTH_RST;
      screen_height_q <= SCREEN_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i;
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Stall only when the skid slot is taken, so a beat accepted now always
  // has a free slot even if the consumer keeps stalling.
  assign in_stall_o = buf_full;
  assign in_fire    = in_valid_i && !buf_full;

  lr_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fire_i          (in_fire),
    .in_i            (in_data_i),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .res_o           (res),
    .busy_o          (busy)
  );

  lr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A pixel is only produced by an accepted advance beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (in_fire && in_data_i.mode == MODE_ADVANCE))
    else $error("pixel produced without an accepted advance beat");

  // The endpoint pixel ends the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res.valid && res.pix.last_pixel) |=> !busy)
    else $error("line still busy after its last pixel");

  // A full buffer always presents a pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_full |-> out_valid_o)
    else $error("skid slot holds a pixel behind an empty output");

  // A full buffer stays full while the consumer stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_full && out_stall_i) |=> buf_full)
    else $error("buffered pixel lost under stall");

endmodule

### rtl/lr_core.sv
`timescale 1ns / 1ps

module lr_core import lr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  lr_in_t              in_i,
  input  logic [SCREEN_W-1:0] screen_width_i,
  input  logic [SCREEN_W-1:0] screen_height_i,
  output lr_res_t             res_o,
  output logic                busy_o
);

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d;
  logic signed [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic signed [COORD_BITS-1:0] target_x_q, target_x_d;
  logic signed [COORD_BITS-1:0] target_y_q, target_y_d;
  logic                         step_x_neg_q, step_x_neg_d;
  logic                         step_y_neg_q, step_y_neg_d;
  logic        [SPAN_W-1:0]     span_x_q, span_x_d;
  logic        [SPAN_W-1:0]     span_y_q, span_y_d;
  logic signed [ERR_W-1:0]      err_q, err_d;
  logic        [COLOR_W-1:0]    color_q, color_d;
  logic                         busy_q, busy_d;

  // start-side spans
  logic signed [SPAN_W-1:0] x0_e, x1_e, y0_e, y1_e;
  logic        [SPAN_W-1:0] sx_new, sy_new;

  // advance-side step
  logic signed [ERR_W:0]    e2, sx_e2, sy_e2;
  logic signed [ERR_W-1:0]  sx_err, sy_err;
  logic                     last, move_x, move_y;
  logic        [CMP_W-1:0]  x_cmp, y_cmp, w_cmp, h_cmp;
  logic                     on;

  assign x0_e = {in_i.x_start[COORD_BITS-1], in_i.x_start};
  assign x1_e = {in_i.x_end[COORD_BITS-1],   in_i.x_end};
  assign y0_e = {in_i.y_start[COORD_BITS-1], in_i.y_start};
  assign y1_e = {in_i.y_end[COORD_BITS-1],   in_i.y_end};
  assign sx_new = (x1_e > x0_e) ? SPAN_W'(x1_e - x0_e) : SPAN_W'(x0_e - x1_e);
  assign sy_new = (y1_e > y0_e) ? SPAN_W'(y1_e - y0_e) : SPAN_W'(y0_e - y1_e);

  assign last   = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);
  assign e2     = {err_q, 1'b0};
  assign sx_e2  = $signed({{(ERR_W+1-SPAN_W){1'b0}}, span_x_q});
  assign sy_e2  = $signed({{(ERR_W+1-SPAN_W){1'b0}}, span_y_q});
  assign sx_err = $signed({{(ERR_W-SPAN_W){1'b0}}, span_x_q});
  assign sy_err = $signed({{(ERR_W-SPAN_W){1'b0}}, span_y_q});
  assign move_x = e2 > -sy_e2;
  assign move_y = e2 < sx_e2;

  // clip test: negative coordinates are off screen, the rest compare unsigned
  assign x_cmp = {{(CMP_W-COORD_BITS){cur_x_q[COORD_BITS-1]}}, cur_x_q};
  assign y_cmp = {{(CMP_W-COORD_BITS){cur_y_q[COORD_BITS-1]}}, cur_y_q};
  assign w_cmp = {{(CMP_W-SCREEN_W){1'b0}}, screen_width_i};
  assign h_cmp = {{(CMP_W-SCREEN_W){1'b0}}, screen_height_i};
  assign on    = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
                 (x_cmp < w_cmp) && (y_cmp < h_cmp);

  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    target_x_d   = target_x_q;
    target_y_d   = target_y_q;
    step_x_neg_d = step_x_neg_q;
    step_y_neg_d = step_y_neg_q;
    span_x_d     = span_x_q;
    span_y_d     = span_y_q;
    err_d        = err_q;
    color_d      = color_q;
    busy_d       = busy_q;

    res_o.valid           = 1'b0;
    res_o.pix.pixel_x     = cur_x_q;
    res_o.pix.pixel_y     = cur_y_q;
    res_o.pix.pixel_color = color_q;
    res_o.pix.on_screen   = on;
    res_o.pix.last_pixel  = last;

    if (fire_i) begin
      case (in_i.mode)
        MODE_START: begin
          cur_x_d      = in_i.x_start;
          cur_y_d      = in_i.y_start;
          target_x_d   = in_i.x_end;
          target_y_d   = in_i.y_end;
          span_x_d     = sx_new;
          span_y_d     = sy_new;
          step_x_neg_d = !(x0_e < x1_e);
          step_y_neg_d = !(y0_e < y1_e);
          err_d        = $signed({{(ERR_W-SPAN_W){1'b0}}, sx_new}) -
                         $signed({{(ERR_W-SPAN_W){1'b0}}, sy_new});
          color_d      = in_i.color;
          busy_d       = 1'b1;
        end
        MODE_ADVANCE: begin
          if (busy_q) begin
            res_o.valid = 1'b1;
            if (last) begin
              busy_d = 1'b0;
            end else begin
              err_d = err_q - (move_x ? sy_err : '0) + (move_y ? sx_err : '0);
              if (move_x) begin
                cur_x_d = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
              end
              if (move_y) begin
                cur_y_d = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      target_x_q   <= '0;
      target_y_q   <= '0;
      step_x_neg_q <= 1'b0;
      step_y_neg_q <= 1'b0;
      span_x_q     <= '0;
      span_y_q     <= '0;
      err_q        <= '0;
      color_q      <= '0;
      busy_q       <= 1'b0;
    end else begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      target_x_q   <= target_x_d;
      target_y_q   <= target_y_d;
      step_x_neg_q <= step_x_neg_d;
      step_y_neg_q <= step_y_neg_d;
      span_x_q     <= span_x_d;
      span_y_q     <= span_y_d;
      err_q        <= err_d;
      color_q      <= color_d;
      busy_q       <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

### rtl/lr_obuf.sv
`timescale 1ns / 1ps

// Two-deep output buffer: main register plus skid register.
module lr_obuf import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  lr_res_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output lr_pix_t out_data_o
);

  logic    out_valid_q;
  lr_pix_t out_q;
  logic    skid_valid_q;
  lr_pix_t skid_q;
  logic    drain;

  assign drain = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (drain) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q  <= res_i.valid;
        end
      end else if (res_i.valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain) begin
      out_q <= skid_valid_q ? skid_q : res_i.pix;
    end else if (res_i.valid) begin
      skid_q <= res_i.pix;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### tb/line_rasterizer_test.sv
`timescale 1ns / 1ps

// Self-checking bench for line_rasterizer.
// A queue of pending input beats feeds a falling-edge driver; a rising-edge
// monitor runs the line predictor on every accepted input beat and checks
// every accepted pixel beat against the oldest predicted pixel.
module line_rasterizer_test;
  import lr_pkg::*;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [SCREEN_W-1:0]  cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  lr_in_t               in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  lr_pix_t              out_data_o;

  line_rasterizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop; far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------
  lr_in_t  pending_q[$];        // input beats not yet presented
  lr_pix_t pixel_expect_q[$];   // predicted pixels, oldest first
  int      error_count   = 0;
  int      pixels_seen   = 0;
  bit      in_beat_taken = 1'b0; // set at the edge that accepts an input beat
  bit      calm          = 1'b0; // no idling on either side while set

  // Shadow of the screen registers (reset values).
  int      scr_w = int'(SCREEN_WIDTH_RST);
  int      scr_h = int'(SCREEN_HEIGHT_RST);

  // Predictor copy of the line state. Plain ints: wide enough that neither
  // the spans nor the error term can wrap.
  int      ln_x, ln_y, ln_tx, ln_ty;
  int      ln_span_x, ln_span_y, ln_err;
  bit      ln_x_back, ln_y_back;
  logic [COLOR_W-1:0] ln_color;
  bit      ln_busy;

  task automatic flag_error(string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 37);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] to_coord(int v);
    return v[COORD_BITS-1:0];
  endfunction

  // One input beat through the line predictor: a start latches the line,
  // an advance while busy yields the current pixel and takes one step.
  task automatic rasterize_beat(lr_in_t beat);
    int      x0, y0, x1, y1, e2;
    bit      at_end;
    lr_pix_t pix;
    if (beat.mode == MODE_START) begin
      x0 = int'(beat.x_start);
      y0 = int'(beat.y_start);
      x1 = int'(beat.x_end);
      y1 = int'(beat.y_end);
      ln_x      = x0;
      ln_y      = y0;
      ln_tx     = x1;
      ln_ty     = y1;
      ln_span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
      ln_span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
      ln_x_back = !(x0 < x1);
      ln_y_back = !(y0 < y1);
      ln_err    = ln_span_x - ln_span_y;
      ln_color  = beat.color;
      ln_busy   = 1'b1;
    end else if (ln_busy) begin
      at_end          = (ln_x == ln_tx) && (ln_y == ln_ty);
      pix.pixel_x     = to_coord(ln_x);
      pix.pixel_y     = to_coord(ln_y);
      pix.pixel_color = ln_color;
      pix.on_screen   = (ln_x >= 0) && (ln_y >= 0) && (ln_x < scr_w) && (ln_y < scr_h);
      pix.last_pixel  = at_end;
      pixel_expect_q.push_back(pix);
      if (at_end) begin
        ln_busy = 1'b0;
      end else begin
        e2 = 2 * ln_err;
        if (e2 > -ln_span_y) begin
          ln_err -= ln_span_y;
          ln_x   += ln_x_back ? -1 : 1;
        end
        if (e2 < ln_span_x) begin
          ln_err += ln_span_x;
          ln_y   += ln_y_back ? -1 : 1;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: input beats and the pixel-side stall change on the falling
  // edge. A new beat is only chosen once the previous one has gone, so a
  // stalled payload holds still.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_beat_taken)) begin
      if (pending_q.size() != 0 && !take_break()) begin
        in_data_i  <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    in_beat_taken = 1'b0;
    out_stall_i <= rst_ni && take_break();
  end

  // ---------------------------------------------------------------------
  // Monitor: predict on input acceptance first, then check the pixel beat,
  // so a same-edge result would still find its expectation.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    lr_pix_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        rasterize_beat(in_data_i);
        in_beat_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        pixels_seen++;
        if (pixel_expect_q.size() == 0) begin
          flag_error($sformatf("pixel %0d (%0d,%0d) with nothing predicted",
                               pixels_seen, out_data_o.pixel_x, out_data_o.pixel_y));
        end else begin
          want = pixel_expect_q.pop_front();
          if (out_data_o.pixel_x !== want.pixel_x)
            flag_error($sformatf("pixel %0d x %0d, want %0d",
                                 pixels_seen, out_data_o.pixel_x, want.pixel_x));
          if (out_data_o.pixel_y !== want.pixel_y)
            flag_error($sformatf("pixel %0d y %0d, want %0d",
                                 pixels_seen, out_data_o.pixel_y, want.pixel_y));
          if (out_data_o.pixel_color !== want.pixel_color)
            flag_error($sformatf("pixel %0d colour %h, want %h",
                                 pixels_seen, out_data_o.pixel_color, want.pixel_color));
          if (out_data_o.on_screen !== want.on_screen)
            flag_error($sformatf("pixel %0d on_screen %b, want %b",
                                 pixels_seen, out_data_o.on_screen, want.on_screen));
          if (out_data_o.last_pixel !== want.last_pixel)
            flag_error($sformatf("pixel %0d last_pixel %b, want %b",
                                 pixels_seen, out_data_o.last_pixel, want.last_pixel));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_start(int x0, int y0, int x1, int y1, int colour);
    lr_in_t beat;
    beat.mode    = MODE_START;
    beat.x_start = to_coord(x0);
    beat.y_start = to_coord(y0);
    beat.x_end   = to_coord(x1);
    beat.y_end   = to_coord(y1);
    beat.color   = colour[COLOR_W-1:0];
    pending_q.push_back(beat);
  endtask

  // Advance beats carry random junk in the fields the block ignores.
  task automatic push_advance(int n);
    lr_in_t      beat;
    logic [95:0] junk;
    repeat (n) begin
      junk      = {$urandom, $urandom, $urandom};
      beat      = junk[$bits(lr_in_t)-1:0];
      beat.mode = MODE_ADVANCE;
      pending_q.push_back(beat);
    end
  endtask

  // Register writes only while the block is idle; one cycle each.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[SCREEN_W-1:0];
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_SCREEN_WIDTH) scr_w = value & 'h7FF;
    else                         scr_h = value & 'h7FF;
  endtask

  // Everything sent and every pixel back, then a further wait, since an
  // idle advance may still be in flight with nothing to show for it.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || pixel_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly whole short lines on or near the screen; some anywhere in the
  // coordinate range, some cut short by a restart, a few stray advances.
  task automatic queue_lines(int quota);
    int done_items, x0, y0, x1, y1, dx, dy, reach, n_pix, n_adv;
    done_items = 0;
    while (done_items < quota) begin
      if ($urandom_range(0, 99) < 8) begin
        push_advance(1);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          x0 = int'(to_coord($urandom));
          y0 = int'(to_coord($urandom));
        end else begin
          x0 = int'($urandom_range(0, scr_w + 40)) - 20;
          y0 = int'($urandom_range(0, scr_h + 40)) - 20;
        end
        reach = ($urandom_range(0, 19) == 0) ? 150 : 12;
        dx = int'($urandom_range(0, 2 * reach)) - reach;
        dy = int'($urandom_range(0, 2 * reach)) - reach;
        if (x0 + dx > 32767 || x0 + dx < -32768) dx = -dx;
        if (y0 + dy > 32767 || y0 + dy < -32768) dy = -dy;
        x1 = x0 + dx;
        y1 = y0 + dy;
        n_pix = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                           : (dy < 0 ? -dy : dy)) + 1;
        if ($urandom_range(0, 99) < 80) n_adv = n_pix + int'($urandom_range(0, 2));
        else                            n_adv = int'($urandom_range(0, n_pix - 1));
        push_start(x0, y0, x1, y1, int'($urandom_range(0, 65535)));
        push_advance(n_adv);
        done_items += 1 + ((n_adv < n_pix) ? n_adv : n_pix);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Run: directed lines at reset sizes, then six phases of random lines,
  // each under its own screen size, the extremes among them.
  // ---------------------------------------------------------------------
  initial begin
    int phase_w[6];
    int phase_h[6];
    phase_w = '{240, 2047, 0, 1, 1, 1024};
    phase_h = '{320, 2047, 0, 1024, 1, 1};
    phase_w[4] = int'($urandom_range(1, 1024));
    phase_h[4] = int'($urandom_range(1, 1024));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Advance straight after reset: nothing may come out.
    push_advance(1);
    // Extreme corners; a few pixels, then restarted while busy.
    push_start(-32768, -32768, 32767, 32767, 'hFFFF);
    push_advance(3);
    // Right/top extreme, stepping backwards along x.
    push_start(32767, 32767, 32760, 32767, 'h0000);
    push_advance(8);
    push_advance(1);  // line already done
    // Single-point line: first advance is also the last pixel.
    push_start(0, 0, 0, 0, 'h5A5A);
    push_advance(1);
    // Diagonal across the bottom-right screen corner.
    push_start(239, 319, 241, 317, 'hA5A5);
    push_advance(3);
    // Short vertical line.
    push_start(5, 2, 5, 4, 'h1234);
    push_advance(3);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        wait_drained();
        write_reg(REG_SCREEN_WIDTH, phase_w[ph]);
        write_reg(REG_SCREEN_HEIGHT, phase_h[ph]);
        @(posedge clk_i);
      end
      calm = (ph == 3);
      queue_lines(217);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lr_pkg.sv
rtl/lr_core.sv
rtl/lr_obuf.sv
rtl/line_rasterizer.sv
tb/line_rasterizer_test.sv
